// ----- hdl/mm64h_pkg.sv -----
// Shared types, constants and helpers for the 64-bit string hash unit.
// No dependencies; compile first.
`default_nettype none

package mm64h_pkg;

	localparam int WORD_W    = 64;
	localparam int HALF_W    = WORD_W / 2;
	localparam int CNT_W     = 4;
	localparam int NUM_BYTES = WORD_W / 8;
	localparam int HASH_SHIFT = 47;

	localparam logic [WORD_W-1:0] HASH_MULT = 64'hc6a4a7935bd1e995;
	localparam logic [HALF_W-1:0] MULT_LO   = HASH_MULT[HALF_W-1:0];
	localparam logic [HALF_W-1:0] MULT_HI   = HASH_MULT[WORD_W-1:HALF_W];

	// Partial product step of the shared 32x32 multiplier
	typedef enum logic [1:0] {
		MS_NONE = 2'd0,
		MS_LL   = 2'd1,	// lo(a) * lo(M), whole product
		MS_HL   = 2'd2,	// hi(a) * lo(M), into upper half
		MS_LH   = 2'd3	// lo(a) * hi(M), into upper half
	} mul_step_t;

	// Operand register source
	typedef enum logic [2:0] {
		OP_HOLD     = 3'd0,
		OP_WORD     = 3'd1,	// incoming full word
		OP_PART     = 3'd2,	// acc ^ masked partial word
		OP_ACC_XS   = 3'd3,	// xorshift(acc)
		OP_PROD_XS  = 3'd4,	// xorshift(product)
		OP_ACC_PROD = 3'd5	// acc ^ product
	} opnd_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_PROD = 2'd1,
		ACC_ZERO = 2'd2
	} acc_sel_t;

	typedef struct packed {
		mul_step_t step;
		opnd_sel_t opnd_sel;
		acc_sel_t  acc_sel;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_full;
		logic cnt_zero;
	} dp_sts_t;

	function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
		return v ^ (v >> HASH_SHIFT);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/mm64h_ifs.sv -----
// Valid/ready channel interfaces for the hash unit: key words in, hashes out.
// Depends on mm64h_pkg.
`default_nettype none

interface mm64h_in_if;
	logic                           valid;
	logic                           ready;
	logic [mm64h_pkg::WORD_W-1:0]   word_data;
	logic [mm64h_pkg::CNT_W-1:0]    byte_count;
	logic                           last_word;

	modport source (output valid, output word_data, output byte_count,
		output last_word, input ready);
	modport sink (input valid, input word_data, input byte_count,
		input last_word, output ready);
endinterface

interface mm64h_out_if;
	logic                           valid;
	logic                           ready;
	logic [mm64h_pkg::WORD_W-1:0]   hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/mm64h_dp.sv -----
// Datapath: accumulator, operand and product registers, shared 32x32 multiplier,
// output hash register. Depends on mm64h_pkg.
`default_nettype none

module mm64h_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [mm64h_pkg::WORD_W-1:0]   word_data,
	input  wire logic [mm64h_pkg::CNT_W-1:0]    byte_count,
	input  wire mm64h_pkg::dp_cmd_t             cmd,
	output mm64h_pkg::dp_sts_t                  sts,
	output logic [mm64h_pkg::WORD_W-1:0]        hash_value
);

	logic [mm64h_pkg::WORD_W-1:0] acc_q;
	logic [mm64h_pkg::WORD_W-1:0] opnd_q;
	logic [mm64h_pkg::WORD_W-1:0] prod_q;
	logic [mm64h_pkg::WORD_W-1:0] out_q;
	logic [mm64h_pkg::WORD_W-1:0] part_word;
	logic [mm64h_pkg::HALF_W-1:0] mul_a;
	logic [mm64h_pkg::HALF_W-1:0] mul_b;
	logic [mm64h_pkg::WORD_W-1:0] mul_p;

	assign sts.cnt_full = (byte_count >= mm64h_pkg::CNT_W'(mm64h_pkg::NUM_BYTES));
	assign sts.cnt_zero = (byte_count == '0);

	// keep bytes below the count
	always_comb begin
		for (int i = 0; i < mm64h_pkg::NUM_BYTES; i++) begin
			part_word[8*i +: 8] = (mm64h_pkg::CNT_W'(i) < byte_count) ?
				word_data[8*i +: 8] : 8'h00;
		end
	end

	assign mul_a = (cmd.step == mm64h_pkg::MS_HL) ?
		opnd_q[mm64h_pkg::WORD_W-1:mm64h_pkg::HALF_W] : opnd_q[mm64h_pkg::HALF_W-1:0];
	assign mul_b = (cmd.step == mm64h_pkg::MS_LH) ? mm64h_pkg::MULT_HI : mm64h_pkg::MULT_LO;
	// 32x32 unsigned; operands zero-extended so the full product is kept
	assign mul_p = mm64h_pkg::WORD_W'(mul_a) * mm64h_pkg::WORD_W'(mul_b);

	always_ff @(posedge clk) begin
		case (cmd.step)
			mm64h_pkg::MS_LL: prod_q <= mul_p;
			mm64h_pkg::MS_HL,
			mm64h_pkg::MS_LH: prod_q[mm64h_pkg::WORD_W-1:mm64h_pkg::HALF_W] <=
				prod_q[mm64h_pkg::WORD_W-1:mm64h_pkg::HALF_W] + mul_p[mm64h_pkg::HALF_W-1:0];
			default: prod_q <= prod_q;
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd.opnd_sel)
			mm64h_pkg::OP_WORD:     opnd_q <= word_data;
			mm64h_pkg::OP_PART:     opnd_q <= acc_q ^ part_word;
			mm64h_pkg::OP_ACC_XS:   opnd_q <= mm64h_pkg::xorshift(acc_q);
			mm64h_pkg::OP_PROD_XS:  opnd_q <= mm64h_pkg::xorshift(prod_q);
			mm64h_pkg::OP_ACC_PROD: opnd_q <= acc_q ^ prod_q;
			default:                opnd_q <= opnd_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (cmd.acc_sel)
				mm64h_pkg::ACC_PROD: acc_q <= prod_q;
				mm64h_pkg::ACC_ZERO: acc_q <= '0;
				default:             acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= mm64h_pkg::xorshift(prod_q);
		end
	end

	assign hash_value = out_q;

endmodule

`default_nettype wire

// ----- hdl/mm64h_ctrl.sv -----
// Controller: sequences multiply passes per word and owns the channel handshakes.
// Depends on mm64h_pkg; drives mm64h_dp through dp_cmd_t.
`default_nettype none

module mm64h_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 last_word,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire mm64h_pkg::dp_sts_t   sts,
	output mm64h_pkg::dp_cmd_t        cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL0 = 5'b00010,
		S_MUL1 = 5'b00100,
		S_MUL2 = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	// which multiply is in flight
	typedef enum logic [3:0] {
		P_K1   = 4'b0001,	// word * M
		P_K2   = 4'b0010,	// xorshift(k) * M
		P_ACC  = 4'b0100,	// (acc ^ k) * M
		P_AVAL = 4'b1000	// avalanche multiply
	} pass_t;

	state_t state_q, state_d;
	pass_t  pass_q, pass_d;
	logic   last_q, last_d;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		pass_d       = pass_q;
		last_d       = last_q;
		cmd.step     = mm64h_pkg::MS_NONE;
		cmd.opnd_sel = mm64h_pkg::OP_HOLD;
		cmd.acc_sel  = mm64h_pkg::ACC_HOLD;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					last_d = last_word;
					if (sts.cnt_full) begin
						cmd.opnd_sel = mm64h_pkg::OP_WORD;
						pass_d       = P_K1;
						state_d      = S_MUL0;
					end else if (!sts.cnt_zero) begin
						cmd.opnd_sel = mm64h_pkg::OP_PART;
						pass_d       = P_ACC;
						state_d      = S_MUL0;
					end else if (last_word) begin
						cmd.opnd_sel = mm64h_pkg::OP_ACC_XS;
						pass_d       = P_AVAL;
						state_d      = S_MUL0;
					end
				end
			end
			S_MUL0: begin
				cmd.step = mm64h_pkg::MS_LL;
				state_d  = S_MUL1;
			end
			S_MUL1: begin
				cmd.step = mm64h_pkg::MS_HL;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.step = mm64h_pkg::MS_LH;
				state_d  = S_DONE;
			end
			S_DONE: begin
				case (pass_q)
					P_K1: begin
						cmd.opnd_sel = mm64h_pkg::OP_PROD_XS;
						pass_d       = P_K2;
						state_d      = S_MUL0;
					end
					P_K2: begin
						cmd.opnd_sel = mm64h_pkg::OP_ACC_PROD;
						pass_d       = P_ACC;
						state_d      = S_MUL0;
					end
					P_ACC: begin
						cmd.acc_sel = mm64h_pkg::ACC_PROD;
						if (last_q) begin
							cmd.opnd_sel = mm64h_pkg::OP_PROD_XS;
							pass_d       = P_AVAL;
							state_d      = S_MUL0;
						end else begin
							state_d = S_IDLE;
						end
					end
					P_AVAL: begin
						// wait here while an earlier hash is still unread
						if (out_free) begin
							cmd.out_load = 1'b1;
							cmd.acc_sel  = mm64h_pkg::ACC_ZERO;
							state_d      = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= P_K1;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			last_q  <= last_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_fire_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !(sts.cnt_zero && !last_word)) |=> (state_q == S_MUL0))
		else $error("accepted word did not start a multiply");

	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL1) |-> $past(state_q == S_MUL0))
		else $error("multiply steps out of order");

	a_hash_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE && pass_q == P_AVAL))
		else $error("hash presented without avalanche pass");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("unread hash overwritten");

endmodule

`default_nettype wire

// ----- hdl/murmur64_string_hash_unit.sv -----
// Top level of the streaming 64-bit string hash (seed zero, length not mixed).
// Depends on mm64h_pkg, mm64h_ifs, mm64h_ctrl and mm64h_dp.
//
// Usage
//   in_ch  : one word per handshake: up to eight key bytes little-endian in
//            word_data, byte_count valid bytes (9..15 count as eight) and
//            last_word on the final word of a key.
//   out_ch : one hash_value per key, presented after its last word.
// Sequencing
//   All arithmetic goes through one shared 32x32 multiplier; each 64-bit
//   multiply by M runs three partial-product steps (MUL0, MUL1, MUL2) and
//   then a DONE step that uses the product.
//   A full word costs 3 multiplies, a partial word 1 multiply, and an empty
//   non-last word none: it is taken and the unit stays ready.
//   The last word adds the avalanche multiply; its DONE step loads the hash
//   into the output register, and the hash is valid on out_ch in the next cycle.
//   in_ch.ready is high only while no word is in progress.
// Reset and stalls
//   arst_n clears the accumulator, the sequencer and the output valid.
//   The finished hash sits in an output register, so the next key's words
//   are taken while it waits; only a further hash waits for out_ch.ready.
`default_nettype none

module murmur64_string_hash_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mm64h_in_if.sink    in_ch,
	mm64h_out_if.source out_ch
);

	mm64h_pkg::dp_cmd_t dp_cmd;
	mm64h_pkg::dp_sts_t dp_sts;

	// sequencer: passes K1 -> K2 -> ACC for a full word, ACC for a partial
	// word, then AVAL when the word is the key's last
	mm64h_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.last_word (in_ch.last_word),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// accumulator, operand/product registers and the hash output register
	mm64h_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_data  (in_ch.word_data),
		.byte_count (in_ch.byte_count),
		.cmd        (dp_cmd),
		.sts        (dp_sts),
		.hash_value (out_ch.hash_value)
	);

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for murmur64_string_hash_unit: key words in, one hash out per key.
// Depends on mm64h_pkg, mm64h_ifs and the unit's RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_top;

	localparam int                          WORD_W     = mm64h_pkg::WORD_W;
	localparam int                          CNT_W      = mm64h_pkg::CNT_W;
	localparam int                          NUM_BYTES  = mm64h_pkg::NUM_BYTES;
	localparam int                          HASH_SHIFT = mm64h_pkg::HASH_SHIFT;
	localparam logic [mm64h_pkg::WORD_W-1:0] HASH_MULT = mm64h_pkg::HASH_MULT;

	localparam int  WORDS_RANDOM = 800;
	localparam int  CALM_FROM    = 250;	// random words with no idling on either side
	localparam int  CALM_TO      = 400;
	localparam int  DRAIN_AT     = 500;	// sender holds off once here until all hashes are in
	localparam int  TAIL_CYCLES  = 40;
	localparam int  DRAIN_LIMIT  = 5000;
	localparam int  IDLE_PCT     = 17;
	localparam real CLK_HALF     = 6.0;

	// One row of the directed table. has_hash marks a row whose hash is typed in;
	// all other rows go through the predictor.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  cnt;
		logic              last;
		logic              has_hash;
		logic [WORD_W-1:0] hash;
	} stim_row_t;

	localparam int N_ROWS = 21;

	logic clk = 1'b0;
	logic arst_n;

	mm64h_in_if  in_ch ();
	mm64h_out_if out_ch ();

	murmur64_string_hash_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Running hash of the key that the bench has handed over so far
	logic [WORD_W-1:0] key_acc;
	// Hashes owed by the unit, oldest first
	logic [WORD_W-1:0] pending_hashes [$];

	int  mismatches   = 0;
	int  words_sent   = 0;
	int  keys_sent    = 0;
	int  hashes_seen  = 0;
	bit  calm         = 1'b0;

	stim_row_t dir_rows [N_ROWS] = '{
		// empty key: the avalanche of zero is zero
		'{64'h0, 4'd0, 1'b1, 1'b1, 64'h0},
		// all-zero full word mixes to zero, so the hash is zero as well
		'{64'h0, 4'd8, 1'b1, 1'b1, 64'h0},
		// empty word mid-key carries junk that must be ignored, then an empty last
		'{64'hdead_beef_cafe_f00d, 4'd0, 1'b0, 1'b0, 64'h0},
		'{64'hffff_ffff_ffff_ffff, 4'd0, 1'b1, 1'b1, 64'h0},
		'{64'hffff_ffff_ffff_ffff, 4'd8, 1'b1, 1'b0, 64'h0},
		'{64'h5555_5555_5555_5555, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b1, 1'b0, 64'h0},
		// partial last words: the bytes above the count are masked off
		'{64'hffff_ffff_ffff_ff5a, 4'd1, 1'b1, 1'b0, 64'h0},
		'{64'hff80_0000_0000_0001, 4'd7, 1'b1, 1'b0, 64'h0},
		// counts above eight saturate to a full word
		'{64'h0123_4567_89ab_cdef, 4'd15, 1'b1, 1'b0, 64'h0},
		'{64'hfedc_ba98_7654_3210, 4'd9, 1'b0, 1'b0, 64'h0},
		'{64'h0, 4'd0, 1'b1, 1'b0, 64'h0},
		// partial word before the last one
		'{64'h1122_3344_5566_7788, 4'd3, 1'b0, 1'b0, 64'h0},
		'{64'h8000_0000_0000_0000, 4'd8, 1'b1, 1'b0, 64'h0},
		// three-word key
		'{64'h0f0f_0f0f_0f0f_0f0f, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'hf0f0_f0f0_f0f0_f0f0, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'h0000_00ff_ffff_ffff, 4'd5, 1'b1, 1'b0, 64'h0},
		// mixed bag of counts in one key
		'{64'h3c3c_3c3c_c3c3_c3c3, 4'd12, 1'b0, 1'b0, 64'h0},
		'{64'h7777_6666_5555_4444, 4'd4, 1'b0, 1'b0, 64'h0},
		'{64'h1357_9bdf_2468_ace0, 4'd0, 1'b0, 1'b0, 64'h0},
		'{64'h7fff_ffff_ffff_ffff, 4'd6, 1'b1, 1'b0, 64'h0}
	};

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Folds one word into the running hash; returns 1 and the finished hash
	// when the word closes the key. Full words take the three-multiply mix,
	// partial words are masked, xored in and multiplied once, empty words do nothing.
	function automatic bit fold_word(input logic [WORD_W-1:0] word,
			input logic [CNT_W-1:0] cnt, input logic last,
			output logic [WORD_W-1:0] hash);
		logic [WORD_W-1:0] k;
		logic [WORD_W-1:0] mask;
		if (cnt >= NUM_BYTES) begin
			k = word * HASH_MULT;
			k = k ^ (k >> HASH_SHIFT);
			k = k * HASH_MULT;
			key_acc = (key_acc ^ k) * HASH_MULT;
		end else if (cnt != 0) begin
			mask = (64'd1 << (cnt * 8)) - 64'd1;
			key_acc = (key_acc ^ (word & mask)) * HASH_MULT;
		end
		hash = '0;
		if (!last)
			return 1'b0;
		// final avalanche, then the key is done
		k = key_acc ^ (key_acc >> HASH_SHIFT);
		k = k * HASH_MULT;
		hash = k ^ (k >> HASH_SHIFT);
		key_acc = '0;
		return 1'b1;
	endfunction

	// Offers one word from a falling edge and returns at the falling edge after
	// its handshake. Random idle cycles go in front, except in the calm stretch.
	// valid is left high, so back-to-back words see no gap unless one is drawn.
	task automatic drive_word(input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] cnt,
			input logic last, input logic has_hash, input logic [WORD_W-1:0] typed_hash);
		logic [WORD_W-1:0] hash;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid      = 1'b0;
			in_ch.word_data  = {$urandom, $urandom};
			in_ch.byte_count = CNT_W'($urandom_range(15));
			in_ch.last_word  = 1'($urandom_range(1));
			@(negedge clk);
		end
		in_ch.valid      = 1'b1;
		in_ch.word_data  = word;
		in_ch.byte_count = cnt;
		in_ch.last_word  = last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		// word taken at this edge: work out what the unit now owes
		if (fold_word(word, cnt, last, hash)) begin
			pending_hashes.push_back(has_hash ? typed_hash : hash);
			keys_sent++;
		end
		words_sent++;
		@(negedge clk);
	endtask

	// Receiver back-pressure, redrawn every falling edge
	always @(negedge clk)
		out_ch.ready = calm || ($urandom_range(99) >= IDLE_PCT);

	// Output checker: each hash taken is matched against the oldest one owed
	always @(posedge clk) begin
		logic [WORD_W-1:0] want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			hashes_seen++;
			if (pending_hashes.size() == 0) begin
				$error("hash_value: none expected, got %h", out_ch.hash_value);
				mismatches++;
			end else begin
				want = pending_hashes.pop_front();
				if (out_ch.hash_value !== want) begin
					$error("hash_value: expected %h, got %h", want, out_ch.hash_value);
					mismatches++;
				end
			end
		end
	end

	// Hard stop in case the unit hangs; far beyond the slowest legal run
	initial begin
		#(400_000 * 2 * CLK_HALF);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int                 r;
		int                 n_full;
		int                 waited;
		bit                 drained;
		logic [CNT_W-1:0]   cnt;

		key_acc          = '0;
		drained          = 1'b0;
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.word_data  = '0;
		in_ch.byte_count = '0;
		in_ch.last_word  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table: extremes of the fields and every special case
		foreach (dir_rows[i])
			drive_word(dir_rows[i].word, dir_rows[i].cnt, dir_rows[i].last,
				dir_rows[i].has_hash, dir_rows[i].hash);

		// Random part. Most of it is well-formed keys: a run of full words
		// (now and then with a count above eight) closed by a last word of 0..8
		// bytes. The rest is loose words with any count and any last flag, which
		// also covers partial and empty words mid-key.
		while (words_sent - N_ROWS < WORDS_RANDOM) begin
			calm = (words_sent - N_ROWS >= CALM_FROM) && (words_sent - N_ROWS < CALM_TO);
			if (!drained && words_sent - N_ROWS >= DRAIN_AT) begin
				// sender holds off until the unit has paid every hash it owes
				in_ch.valid = 1'b0;
				while (pending_hashes.size() != 0)
					@(negedge clk);
				drained = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 80) begin
				n_full = $urandom_range(5);
				repeat (n_full) begin
					cnt = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(15, 9)) : CNT_W'(8);
					drive_word({$urandom, $urandom}, cnt, 1'b0, 1'b0, '0);
				end
				drive_word({$urandom, $urandom}, CNT_W'($urandom_range(8)), 1'b1, 1'b0, '0);
			end else begin
				drive_word({$urandom, $urandom}, CNT_W'($urandom_range(15)),
					1'($urandom_range(1)), 1'b0, '0);
			end
		end
		calm = 1'b0;
		in_ch.valid = 1'b0;

		// Wait for the owed hashes, bounded, then let the pipeline run dry
		waited = 0;
		while (pending_hashes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_hashes.size() != 0) begin
			$error("hash_value: %0d expected hashes never arrived", pending_hashes.size());
			mismatches += pending_hashes.size();
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Drove %0d words (%0d from the directed table) making up %0d keys;",
			words_sent, N_ROWS, keys_sent);
		$display("checked %0d hashes, %0d mismatches.", hashes_seen, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
